@@ src/rgcsi_pkg.sv @@
`timescale 1ns / 1ps

package rgcsi_pkg;

  // Number formats of the ray and the cube.
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned DIR_WIDTH   = 18;
  localparam int unsigned CELL_WIDTH  = 16;
  localparam int unsigned GRID_WIDTH  = 31;
  localparam logic [GRID_WIDTH-1:0] GRID_RESET = GRID_WIDTH'(65536);

  // Slab arithmetic is carried at this width so no bound or difference wraps.
  localparam int unsigned NUM_WIDTH = 52;

  // Quotient bits below saturation, and the dividend bits the divider needs.
  localparam int unsigned QUO_BITS  = COORD_WIDTH - 1;
  localparam int unsigned DIVD_BITS = COORD_WIDTH;
  localparam int unsigned OVF_SHIFT = QUO_BITS - FRAC_BITS;

  localparam int unsigned IN_BITS  = 3 * COORD_WIDTH + 3 * DIR_WIDTH + 3 * CELL_WIDTH;
  localparam int unsigned IN_BYTES_BITS  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS = 4 * COORD_WIDTH + 3;
  localparam int unsigned OUT_BYTES_BITS = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    FACE_NONE  = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_X = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Y = 3'd4,
    FACE_NEG_Z = 3'd5,
    FACE_POS_Z = 3'd6
  } face_e;

  // Per-axis facts that travel beside the divider.
  typedef struct packed {
    logic                          ovf_lo;
    logic                          ovf_hi;
    logic                          neg_lo;
    logic                          neg_hi;
    logic                          dir_zero;
    logic                          contained;
    logic signed [COORD_WIDTH-1:0] org;
    logic signed [DIR_WIDTH-1:0]   dir;
  } axis_side_t;

  typedef struct packed {
    logic       valid;
    axis_side_t x;
    axis_side_t y;
    axis_side_t z;
  } ray_side_t;

endpackage

@@ src/rgcsi_div.sv @@
`timescale 1ns / 1ps

// Unsigned restoring divider, one quotient bit per pipeline stage.
// Computes floor((a << FRAC) / b) for results below 2^QB.
module rgcsi_div #(
  parameter int unsigned QB   = 31,
  parameter int unsigned FB   = 16,
  parameter int unsigned AW   = 32,
  parameter int unsigned BW   = 18
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic [QB-1:0] quo_o
);

  logic [BW-1:0] rem_q [QB+1];
  logic [BW-1:0] den_q [QB+1];
  logic [AW-1:0] num_q [QB+1];
  logic [QB-1:0] quo_q [QB+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= BW'(a_i >> (QB - FB));
      den_q[0] <= b_i;
      num_q[0] <= a_i;
      quo_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int unsigned J = QB - 1 - k;
    logic        in_bit;
    logic [BW:0] trial;
    logic        take;

    if (J >= FB) begin : g_num
      assign in_bit = num_q[k][J-FB];
    end else begin : g_zero
      assign in_bit = 1'b0;
    end

    assign trial = {rem_q[k], in_bit};
    assign take  = trial >= {1'b0, den_q[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= take ? BW'(trial - {1'b0, den_q[k]}) : BW'(trial);
        den_q[k+1] <= den_q[k];
        num_q[k+1] <= num_q[k];
        quo_q[k+1] <= quo_q[k] | (QB'(take) << J);
      end
    end
  end

  assign quo_o = quo_q[QB];

endmodule

@@ src/ray_grid_cube_slab_intersect_top.sv @@
`timescale 1ns / 1ps

// Channel   | Direction | Signals                              | Carries
// ----------+-----------+--------------------------------------+---------------------------
// s_axis    | in        | s_axis_tvalid/tready/tdata           | one ray and one grid cell
// m_axis    | out       | m_axis_tvalid/tready/tdata/tuser     | hit flag, distance, point
// cfg       | in        | cfg_valid_i/cfg_ready_o/cfg_data_i   | grid cube edge length
//
// One ray enters per cycle while the pipeline is not held; its result passes through the
// five front stages, 32 divider stages, five back stages and the result register, in
// that order; the six slab dividers resolve one quotient bit per stage.
// Reset (rst_ni low) empties the pipeline and sets the grid size to 1.0.
// When the result register is full and m_axis_tready is low, the whole pipeline holds.
// Configuration writes are always accepted and take effect for the next accepted ray.
module ray_grid_cube_slab_intersect_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // s_axis_tdata, low bit first: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
  // cell_x, cell_y, cell_z, zero fill.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rgcsi_pkg::IN_BYTES_BITS-1:0] s_axis_tdata,
  // m_axis_tdata, low bit first: t_hit, hit_x, hit_y, hit_z, normal_code, zero fill.
  // m_axis_tuser: hit_flag.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rgcsi_pkg::OUT_BYTES_BITS-1:0] m_axis_tdata,
  output logic                              m_axis_tuser,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rgcsi_pkg::GRID_WIDTH-1:0]  cfg_data_i
);

  import rgcsi_pkg::*;

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned DW  = DIR_WIDTH;
  localparam int unsigned NW  = NUM_WIDTH;
  localparam int unsigned LAT = QUO_BITS + 1;
  localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  // The pipeline advances whenever the result register can take a new value.
  logic ce;
  logic out_valid_q;

  assign ce            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = ce;
  assign cfg_ready_o   = 1'b1;

  logic [GRID_WIDTH-1:0] grid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= GRID_RESET;
    end else if (cfg_valid_i) begin
      grid_q <= cfg_data_i;
    end
  end

  // Input unpacking.
  logic signed [CW-1:0]         in_org  [3];
  logic signed [DW-1:0]         in_dir  [3];
  logic signed [CELL_WIDTH-1:0] in_cell [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_org[i]  = s_axis_tdata[CW*i +: CW];
      in_dir[i]  = s_axis_tdata[3*CW + DW*i +: DW];
      in_cell[i] = s_axis_tdata[3*CW + 3*DW + CELL_WIDTH*i +: CELL_WIDTH];
    end
  end

  // Valid bits of the front stages and of the back stages.
  logic [4:0] fv_q;
  logic [LAT-1:0] dv_q;
  logic [4:0] bv_q;

  // Stage 1: cell index times grid size.
  logic signed [CELL_WIDTH+CW-1:0] s1_prod_q [3];
  logic signed [CW-1:0]            s1_org_q  [3];
  logic signed [DW-1:0]            s1_dir_q  [3];
  logic [GRID_WIDTH-1:0]           s1_g_q;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        s1_prod_q[i] <= in_cell[i] * $signed({1'b0, grid_q});
        s1_org_q[i]  <= in_org[i];
        s1_dir_q[i]  <= in_dir[i];
      end
      s1_g_q <= grid_q;
    end
  end

  // Stage 2: slab bounds. The y slab starts at the cell corner, x and z are centered.
  logic signed [NW-1:0] s2_lo_q  [3];
  logic signed [NW-1:0] s2_hi_q  [3];
  logic signed [CW-1:0] s2_org_q [3];
  logic signed [DW-1:0] s2_dir_q [3];
  logic signed [NW-1:0] half_g;
  logic signed [NW-1:0] rest_g;
  logic signed [NW-1:0] full_g;

  assign half_g = NW'(s1_g_q >> 1);
  assign full_g = NW'(s1_g_q);
  assign rest_g = full_g - half_g;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        if (i == 1) begin
          s2_lo_q[i] <= NW'(s1_prod_q[i]);
          s2_hi_q[i] <= NW'(s1_prod_q[i]) + full_g;
        end else begin
          s2_lo_q[i] <= NW'(s1_prod_q[i]) - half_g;
          s2_hi_q[i] <= NW'(s1_prod_q[i]) + rest_g;
        end
        s2_org_q[i] <= s1_org_q[i];
        s2_dir_q[i] <= s1_dir_q[i];
      end
    end
  end

  // Stage 3: distances from the origin to both bounds, and the containment check.
  logic signed [NW-1:0] s3_nlo_q [3];
  logic signed [NW-1:0] s3_nhi_q [3];
  logic                 s3_in_q  [3];
  logic signed [CW-1:0] s3_org_q [3];
  logic signed [DW-1:0] s3_dir_q [3];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        s3_nlo_q[i] <= s2_lo_q[i] - NW'(s2_org_q[i]);
        s3_nhi_q[i] <= s2_hi_q[i] - NW'(s2_org_q[i]);
        s3_in_q[i]  <= (NW'(s2_org_q[i]) >= s2_lo_q[i]) && (NW'(s2_org_q[i]) <= s2_hi_q[i]);
        s3_org_q[i] <= s2_org_q[i];
        s3_dir_q[i] <= s2_dir_q[i];
      end
    end
  end

  // Stage 4: magnitudes and quotient signs.
  logic [NW-1:0]        s4_alo_q [3];
  logic [NW-1:0]        s4_ahi_q [3];
  logic [DW-1:0]        s4_b_q   [3];
  logic                 s4_nlo_q [3];
  logic                 s4_nhi_q [3];
  logic                 s4_in_q  [3];
  logic signed [CW-1:0] s4_org_q [3];
  logic signed [DW-1:0] s4_dir_q [3];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        s4_alo_q[i] <= s3_nlo_q[i][NW-1] ? NW'(-s3_nlo_q[i]) : NW'(s3_nlo_q[i]);
        s4_ahi_q[i] <= s3_nhi_q[i][NW-1] ? NW'(-s3_nhi_q[i]) : NW'(s3_nhi_q[i]);
        s4_b_q[i]   <= s3_dir_q[i][DW-1] ? DW'(-s3_dir_q[i]) : DW'(s3_dir_q[i]);
        s4_nlo_q[i] <= (s3_nlo_q[i] != '0) && (s3_nlo_q[i][NW-1] != s3_dir_q[i][DW-1]);
        s4_nhi_q[i] <= (s3_nhi_q[i] != '0) && (s3_nhi_q[i][NW-1] != s3_dir_q[i][DW-1]);
        s4_in_q[i]  <= s3_in_q[i];
        s4_org_q[i] <= s3_org_q[i];
        s4_dir_q[i] <= s3_dir_q[i];
      end
    end
  end

  // Stage 5: saturation check, which also bounds the dividend to DIVD_BITS.
  logic [DIVD_BITS-1:0] s5_alo_q  [3];
  logic [DIVD_BITS-1:0] s5_ahi_q  [3];
  logic [DW-1:0]        s5_b_q    [3];
  axis_side_t           s5_side_q [3];
  logic [NW-1:0]        lim       [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lim[i] = NW'(s4_b_q[i]) << OVF_SHIFT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        s5_alo_q[i]            <= DIVD_BITS'(s4_alo_q[i]);
        s5_ahi_q[i]            <= DIVD_BITS'(s4_ahi_q[i]);
        s5_b_q[i]              <= s4_b_q[i];
        s5_side_q[i].ovf_lo    <= s4_alo_q[i] >= lim[i];
        s5_side_q[i].ovf_hi    <= s4_ahi_q[i] >= lim[i];
        s5_side_q[i].neg_lo    <= s4_nlo_q[i];
        s5_side_q[i].neg_hi    <= s4_nhi_q[i];
        s5_side_q[i].dir_zero  <= s4_dir_q[i] == '0;
        s5_side_q[i].contained <= s4_in_q[i];
        s5_side_q[i].org       <= s4_org_q[i];
        s5_side_q[i].dir       <= s4_dir_q[i];
      end
    end
  end

  // Six dividers, two bounds per axis.
  logic [QUO_BITS-1:0] quo_lo [3];
  logic [QUO_BITS-1:0] quo_hi [3];

  for (genvar i = 0; i < 3; i++) begin : g_axis
    rgcsi_div #(
      .QB(QUO_BITS), .FB(FRAC_BITS), .AW(DIVD_BITS), .BW(DW)
    ) u_div_lo (
      .clk_i(clk_i), .en_i(ce), .a_i(s5_alo_q[i]), .b_i(s5_b_q[i]), .quo_o(quo_lo[i])
    );
    rgcsi_div #(
      .QB(QUO_BITS), .FB(FRAC_BITS), .AW(DIVD_BITS), .BW(DW)
    ) u_div_hi (
      .clk_i(clk_i), .en_i(ce), .a_i(s5_ahi_q[i]), .b_i(s5_b_q[i]), .quo_o(quo_hi[i])
    );
  end

  // Sideband delay line matched to the divider latency.
  ray_side_t side_q [LAT];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      side_q[0].valid <= 1'b0;
      side_q[0].x     <= s5_side_q[0];
      side_q[0].y     <= s5_side_q[1];
      side_q[0].z     <= s5_side_q[2];
      for (int k = 1; k < LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  axis_side_t d_side [3];

  assign d_side[0] = side_q[LAT-1].x;
  assign d_side[1] = side_q[LAT-1].y;
  assign d_side[2] = side_q[LAT-1].z;

  // Back stage 1: signed, saturated slab distances.
  logic signed [CW-1:0] b1_tlo_q  [3];
  logic signed [CW-1:0] b1_thi_q  [3];
  axis_side_t           b1_side_q [3];

  function automatic logic signed [CW-1:0] sat_dist(
    input logic [QUO_BITS-1:0] q,
    input logic                ovf,
    input logic                neg
  );
    logic [CW:0] mag;
    mag = ovf ? (CW+1)'(1) << (CW - 1) : (CW+1)'(q);
    if (neg) begin
      return CW'(-mag);
    end
    return ovf ? SAT_MAX : CW'(q);
  endfunction

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        b1_tlo_q[i]  <= sat_dist(quo_lo[i], d_side[i].ovf_lo, d_side[i].neg_lo);
        b1_thi_q[i]  <= sat_dist(quo_hi[i], d_side[i].ovf_hi, d_side[i].neg_hi);
        b1_side_q[i] <= d_side[i];
      end
    end
  end

  // Back stage 2: order the two distances per axis and pick the near face.
  logic signed [CW-1:0] b2_tn_q   [3];
  logic signed [CW-1:0] b2_tf_q   [3];
  face_e                b2_fn_q   [3];
  axis_side_t           b2_side_q [3];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        if (b1_tlo_q[i] > b1_thi_q[i]) begin
          b2_tn_q[i] <= b1_thi_q[i];
          b2_tf_q[i] <= b1_tlo_q[i];
          b2_fn_q[i] <= face_e'(3'(2 * i + 2));
        end else begin
          b2_tn_q[i] <= b1_tlo_q[i];
          b2_tf_q[i] <= b1_thi_q[i];
          b2_fn_q[i] <= face_e'(3'(2 * i + 1));
        end
        b2_side_q[i] <= b1_side_q[i];
      end
    end
  end

  // Slab update for one axis; once an axis misses, the ray has missed.
  typedef struct packed {
    logic                 ok;
    logic signed [CW-1:0] tmin;
    logic signed [CW-1:0] tmax;
    face_e                face;
  } span_t;

  function automatic span_t slab_step(
    input span_t                s,
    input logic                 dz,
    input logic                 contained,
    input logic signed [CW-1:0] tn,
    input logic signed [CW-1:0] tf,
    input face_e                fn
  );
    span_t r;
    r = s;
    if (s.ok) begin
      if (dz) begin
        r.ok = contained;
      end else begin
        if (tn > s.tmin) begin
          r.tmin = tn;
          r.face = fn;
        end
        if (tf < s.tmax) begin
          r.tmax = tf;
        end
        r.ok = r.tmin <= r.tmax;
      end
    end
    return r;
  endfunction

  // Back stage 3: x and y slabs.
  span_t      b3_span_q;
  span_t      span_init;
  span_t      span_x;
  axis_side_t b3_side_q [3];
  logic signed [CW-1:0] b3_tn_q;
  logic signed [CW-1:0] b3_tf_q;
  face_e                b3_fn_q;

  assign span_init = '{ok: 1'b1, tmin: '0, tmax: SAT_MAX, face: FACE_NONE};
  assign span_x = slab_step(span_init, b2_side_q[0].dir_zero, b2_side_q[0].contained,
                            b2_tn_q[0], b2_tf_q[0], b2_fn_q[0]);

  always_ff @(posedge clk_i) begin
    if (ce) begin
      b3_span_q <= slab_step(span_x, b2_side_q[1].dir_zero, b2_side_q[1].contained,
                             b2_tn_q[1], b2_tf_q[1], b2_fn_q[1]);
      b3_tn_q   <= b2_tn_q[2];
      b3_tf_q   <= b2_tf_q[2];
      b3_fn_q   <= b2_fn_q[2];
      for (int i = 0; i < 3; i++) begin
        b3_side_q[i] <= b2_side_q[i];
      end
    end
  end

  // Back stage 4: z slab, then reject a box that lies wholly behind the origin.
  span_t span_z;
  span_t b4_span_q;
  logic signed [CW-1:0] b4_org_q [3];
  logic signed [DW-1:0] b4_dir_q [3];

  assign span_z = slab_step(b3_span_q, b3_side_q[2].dir_zero, b3_side_q[2].contained,
                            b3_tn_q, b3_tf_q, b3_fn_q);

  always_ff @(posedge clk_i) begin
    if (ce) begin
      b4_span_q <= '{ok: span_z.ok && !span_z.tmax[CW-1], tmin: span_z.tmin,
                     tmax: span_z.tmax, face: span_z.face};
      for (int i = 0; i < 3; i++) begin
        b4_org_q[i] <= b3_side_q[i].org;
        b4_dir_q[i] <= b3_side_q[i].dir;
      end
    end
  end

  // Back stage 5: direction magnitude times the entry distance, which is never negative.
  logic [DW+CW-2:0]     b5_prod_q [3];
  logic                 b5_dneg_q [3];
  logic signed [CW-1:0] b5_org_q  [3];
  span_t                b5_span_q;
  logic [DW-1:0]        dir_mag   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir_mag[i] = b4_dir_q[i][DW-1] ? DW'(-b4_dir_q[i]) : DW'(b4_dir_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        b5_prod_q[i] <= dir_mag[i] * b4_span_q.tmin[CW-2:0];
        b5_dneg_q[i] <= b4_dir_q[i][DW-1];
        b5_org_q[i]  <= b4_org_q[i];
      end
      b5_span_q <= b4_span_q;
    end
  end

  // Result stage: hit point, saturated; a miss clears every field.
  localparam int unsigned PW = DW + CW - 1 - FRAC_BITS;
  localparam int unsigned SW = PW + 2;

  logic signed [SW-1:0] pt_sum [3];
  logic signed [CW-1:0] pt_sat [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (b5_dneg_q[i]) begin
        pt_sum[i] = SW'(b5_org_q[i]) - $signed(SW'(b5_prod_q[i][DW+CW-2:FRAC_BITS]));
      end else begin
        pt_sum[i] = SW'(b5_org_q[i]) + $signed(SW'(b5_prod_q[i][DW+CW-2:FRAC_BITS]));
      end
      if (pt_sum[i] > SW'(SAT_MAX)) begin
        pt_sat[i] = SAT_MAX;
      end else if (pt_sum[i] < SW'(SAT_MIN)) begin
        pt_sat[i] = SAT_MIN;
      end else begin
        pt_sat[i] = CW'(pt_sum[i]);
      end
    end
  end

  logic                 hit_q;
  logic signed [CW-1:0] t_hit_q;
  logic signed [CW-1:0] hit_pt_q [3];
  face_e                face_q;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      hit_q   <= b5_span_q.ok;
      t_hit_q <= b5_span_q.ok ? b5_span_q.tmin : '0;
      face_q  <= b5_span_q.ok ? b5_span_q.face : FACE_NONE;
      for (int i = 0; i < 3; i++) begin
        hit_pt_q[i] <= b5_span_q.ok ? pt_sat[i] : '0;
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q        <= '0;
      dv_q        <= '0;
      bv_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (ce) begin
      fv_q        <= {fv_q[3:0], s_axis_tvalid};
      dv_q        <= {dv_q[LAT-2:0], fv_q[4]};
      bv_q        <= {bv_q[3:0], dv_q[LAT-1]};
      out_valid_q <= bv_q[4];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = hit_q;
  assign m_axis_tdata  = OUT_BYTES_BITS'({face_q, hit_pt_q[2], hit_pt_q[1], hit_pt_q[0],
                                          t_hit_q});

  // A miss carries an all-zero payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss result with nonzero payload");

  // A hit that names no entry face, as when the origin is contained, has an entry distance of zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser && (face_q == FACE_NONE) |-> t_hit_q == '0)
    else $error("hit without entry face has nonzero distance");

  // Hits lie at or ahead of the origin.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> !t_hit_q[CW-1])
    else $error("hit distance is negative");

  // A stalled result register freezes the pipeline, so no valid bit moves.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(bv_q) && $stable(fv_q))
    else $error("pipeline moved while the output was stalled");

endmodule

@@ tb/tb_ray_grid_cube_slab_intersect_top.sv @@
`timescale 1ns / 1ps

module tb_ray_grid_cube_slab_intersect_top;
  import rgcsi_pkg::*;

  localparam longint SAT_MAX = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
  localparam longint SAT_MIN = -(longint'(1) <<< (COORD_WIDTH - 1));
  localparam logic [63:0] SAT_MAG = 64'd1 << (COORD_WIDTH - 1);
  localparam int DRAIN_CYCLES = 64;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] org [3];
    logic signed [DIR_WIDTH-1:0]   dir [3];
    logic signed [CELL_WIDTH-1:0]  idx [3];
  } ray_t;

  typedef struct packed {
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] t;
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
    logic signed [COORD_WIDTH-1:0] pz;
    face_e                         face;
  } hit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_BYTES_BITS-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_BYTES_BITS-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [GRID_WIDTH-1:0] cfg_data_i = '0;

  ray_t rays_pending [$];
  hit_t hits_expected [$];
  logic [GRID_WIDTH-1:0] cube_edge = GRID_RESET;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;

  ray_grid_cube_slab_intersect_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint clamp_coord(longint v);
    if (v > SAT_MAX) return SAT_MAX;
    if (v < SAT_MIN) return SAT_MIN;
    return v;
  endfunction

  // (num << FRAC_BITS) / den, truncated toward zero and saturated.
  function automatic longint slab_dist(longint num, longint den);
    bit neg;
    logic [63:0] a, b, qi, r, mag;
    neg = (num < 0) != (den < 0);
    a = num < 0 ? -num : num;
    b = den < 0 ? -den : den;
    qi = a / b;
    r = a % b;
    if (qi > (SAT_MAG >> FRAC_BITS)) begin
      mag = SAT_MAG;
    end else begin
      mag = (qi << FRAC_BITS) + ((r << FRAC_BITS) / b);
      if (mag > SAT_MAG) mag = SAT_MAG;
    end
    if (neg) return -longint'(mag);
    return mag > SAT_MAX ? SAT_MAX : longint'(mag);
  endfunction

  function automatic longint step_along(longint org, longint dir, longint t);
    logic [63:0] dm, p;
    dm = dir < 0 ? -dir : dir;
    p = (dm * t) >> FRAC_BITS;
    return clamp_coord(org + (dir < 0 ? -longint'(p) : longint'(p)));
  endfunction

  function automatic hit_t intersect_cube(ray_t r, logic [GRID_WIDTH-1:0] edge_len);
    face_e near_face [3] = '{FACE_NEG_X, FACE_NEG_Y, FACE_NEG_Z};
    face_e far_face [3] = '{FACE_POS_X, FACE_POS_Y, FACE_POS_Z};
    longint g, h, org, dir, lo, hi, t1, t2, tt, tmin, tmax;
    face_e f1, f2, ft, face;
    bit ok;
    hit_t res;
    g = longint'(edge_len);
    h = g >>> 1;
    tmin = 0;
    tmax = SAT_MAX;
    face = FACE_NONE;
    ok = 1'b1;
    for (int i = 0; i < 3 && ok; i++) begin
      org = r.org[i];
      dir = r.dir[i];
      lo = longint'(r.idx[i]) * g - (i == 1 ? 0 : h);
      hi = lo + g;
      if (dir == 0) begin
        // Parallel to this slab: the origin must already lie between the planes.
        ok = org >= lo && org <= hi;
      end else begin
        t1 = slab_dist(lo - org, dir);
        t2 = slab_dist(hi - org, dir);
        f1 = near_face[i];
        f2 = far_face[i];
        if (t1 > t2) begin
          tt = t1; t1 = t2; t2 = tt;
          ft = f1; f1 = f2; f2 = ft;
        end
        if (t1 > tmin) begin
          tmin = t1;
          face = f1;
        end
        if (t2 < tmax) tmax = t2;
        ok = tmin <= tmax;
      end
    end
    if (ok && tmax < 0) ok = 1'b0;
    res = '{hit: 1'b0, t: '0, px: '0, py: '0, pz: '0, face: FACE_NONE};
    if (ok) begin
      tt = tmin >= 0 ? tmin : tmax;
      res.hit = 1'b1;
      res.t = tt[COORD_WIDTH-1:0];
      res.px = COORD_WIDTH'(step_along(r.org[0], r.dir[0], tt));
      res.py = COORD_WIDTH'(step_along(r.org[1], r.dir[1], tt));
      res.pz = COORD_WIDTH'(step_along(r.org[2], r.dir[2], tt));
      res.face = face;
    end
    return res;
  endfunction

  function automatic logic [IN_BYTES_BITS-1:0] pack_ray(ray_t r);
    return IN_BYTES_BITS'({r.idx[2], r.idx[1], r.idx[0], r.dir[2], r.dir[1], r.dir[0],
                           r.org[2], r.org[1], r.org[0]});
  endfunction

  // Driver: presents the head of the pending queue and predicts on acceptance.
  always @(posedge clk_i) begin
    bit taken;
    taken = s_axis_tvalid && s_axis_tready;
    if (taken) begin
      hits_expected.push_back(intersect_cube(rays_pending[0], cube_edge));
      void'(rays_pending.pop_front());
    end
    if (rst_ni && (!s_axis_tvalid || taken)) begin
      if (rays_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pack_ray(rays_pending[0]);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compares each result transaction with the oldest prediction.
  always @(posedge clk_i) begin
    hit_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.hit = m_axis_tuser;
      got.t = m_axis_tdata[31:0];
      got.px = m_axis_tdata[63:32];
      got.py = m_axis_tdata[95:64];
      got.pz = m_axis_tdata[127:96];
      got.face = face_e'(m_axis_tdata[130:128]);
      if (hits_expected.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
      end else begin
        want = hits_expected.pop_front();
        if (got.hit !== want.hit) begin
          mismatches++;
          $display("%0t: hit_flag expected %0d actual %0d", $time, want.hit, got.hit);
        end
        if (got.t !== want.t) begin
          mismatches++;
          $display("%0t: t_hit expected %0d actual %0d", $time, want.t, got.t);
        end
        if (got.px !== want.px) begin
          mismatches++;
          $display("%0t: hit_x expected %0d actual %0d", $time, want.px, got.px);
        end
        if (got.py !== want.py) begin
          mismatches++;
          $display("%0t: hit_y expected %0d actual %0d", $time, want.py, got.py);
        end
        if (got.pz !== want.pz) begin
          mismatches++;
          $display("%0t: hit_z expected %0d actual %0d", $time, want.pz, got.pz);
        end
        if (got.face !== want.face) begin
          mismatches++;
          $display("%0t: normal_code expected %0d actual %0d", $time, want.face, got.face);
        end
      end
    end
    if (rst_ni) m_axis_tready <= $urandom_range(0, 99) >= recv_stall_pct;
  end

  task automatic add_ray(longint ox, longint oy, longint oz, int dx, int dy, int dz,
                         int cx, int cy, int cz);
    ray_t r;
    r.org[0] = COORD_WIDTH'(ox); r.org[1] = COORD_WIDTH'(oy); r.org[2] = COORD_WIDTH'(oz);
    r.dir[0] = DIR_WIDTH'(dx); r.dir[1] = DIR_WIDTH'(dy); r.dir[2] = DIR_WIDTH'(dz);
    r.idx[0] = CELL_WIDTH'(cx); r.idx[1] = CELL_WIDTH'(cy); r.idx[2] = CELL_WIDTH'(cz);
    rays_pending.push_back(r);
  endtask

  function automatic int rand_dir();
    if ($urandom_range(0, 9) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return int'($urandom_range(0, 262143)) - 131072;
    return int'($urandom_range(0, 131072)) - 65536;
  endfunction

  // Mostly rays aimed through a random point of the cube from some distance, plus raw noise.
  task automatic add_random_ray();
    ray_t r;
    longint g, k, center;
    g = longint'(cube_edge);
    if ($urandom_range(0, 9) < 3) begin
      for (int i = 0; i < 3; i++) begin
        r.org[i] = $urandom();
        r.dir[i] = DIR_WIDTH'($urandom());
        r.idx[i] = CELL_WIDTH'($urandom());
      end
    end else begin
      k = longint'($urandom_range(0, 1023)) * (g > 0 ? g : 1) / 64;
      for (int i = 0; i < 3; i++) begin
        r.idx[i] = CELL_WIDTH'(int'($urandom_range(0, 16)) - 8);
        r.dir[i] = DIR_WIDTH'(rand_dir());
        center = longint'(r.idx[i]) * g + (i == 1 ? g / 2 : 0);
        center = center + (longint'($urandom_range(0, 255)) - 128) * g / 256;
        r.org[i] = COORD_WIDTH'(clamp_coord(center -
                                            ((longint'(r.dir[i]) * k) >>> FRAC_BITS)));
      end
    end
    rays_pending.push_back(r);
  endtask

  task automatic drain();
    while (rays_pending.size() > 0 || hits_expected.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_edge(logic [GRID_WIDTH-1:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cube_edge = v;
  endtask

  initial begin
    logic [GRID_WIDTH-1:0] edges [6];
    edges = '{GRID_RESET, GRID_WIDTH'(1), GRID_WIDTH'(0), {GRID_WIDTH{1'b1}},
              31'h0000_0001 << 20, 31'd196608};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rays against the unit cube, most of them at the origin cell.
    add_ray(-3 * 65536, 32768, 0, 65536, 0, 0, 0, 0, 0);
    add_ray(3 * 65536, 32768, 0, -65536, 0, 0, 0, 0, 0);
    add_ray(0, -2 * 65536, 0, 0, 65536, 0, 0, 0, 0);
    add_ray(0, 3 * 65536, 0, 0, -65536, 0, 0, 0, 0);
    add_ray(0, 32768, -5 * 65536, 0, 0, 65536, 0, 0, 0);
    add_ray(0, 32768, 4 * 65536, 0, 0, -65536, 0, 0, 0);
    add_ray(0, 32768, 0, 46341, 46341, 0, 0, 0, 0);          // origin inside
    add_ray(3 * 65536, 32768, 0, 65536, 0, 0, 0, 0, 0);      // cube behind the ray
    add_ray(0, 5 * 65536, 0, 65536, 0, 0, 0, 0, 0);          // parallel, outside
    add_ray(-32768, 65536, 32768, 0, 0, 0, 0, 0, 0);         // zero direction, on corner
    add_ray(-65536, 0, -65536, 46341, 46341, 0, 0, 0, 0);    // tie on edge
    add_ray(-2 * 65536, 32768, 0, 131071, 0, 0, 0, 0, 0);    // oversized direction
    add_ray(2 * 65536, 32768, 0, -131072, 1, -1, 0, 0, 0);
    add_ray(SAT_MIN, SAT_MIN, SAT_MIN, 65536, 65536, 65536, 0, 0, 0);
    add_ray(SAT_MAX, SAT_MAX, SAT_MAX, -65536, -65536, -65536, 0, 0, 0);
    add_ray(0, 0, 0, 65536, 65536, 65536, 32767, 32767, 32767);
    add_ray(0, 0, 0, -65536, -65536, -65536, -32768, -32768, -32768);
    add_ray(SAT_MIN, 0, SAT_MAX, 1, 0, -1, -32768, 0, 32767);
    add_ray(0, 32768, 0, 1, 1, 1, 0, 0, 0);
    add_ray(-1, -1, -1, -1, -1, -1, -1, -1, -1);
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p > 0) write_edge(edges[p]);
      for (int m = 0; m < 4; m++) begin
        send_idle_pct = (m == 1) ? 61 : (m == 3) ? 11 : 0;
        recv_stall_pct = (m == 2) ? 61 : (m == 3) ? 11 : 0;
        repeat (21) add_random_ray();
        while (rays_pending.size() > 0) @(posedge clk_i);
      end
      drain();
    end

    if (mismatches == 0 && hits_expected.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ ray_grid_cube_slab_intersect_top.f @@
src/rgcsi_pkg.sv
src/rgcsi_div.sv
src/ray_grid_cube_slab_intersect_top.sv
tb/tb_ray_grid_cube_slab_intersect_top.sv
